FILE: src/tscd_pkg.sv
// Shared types and constants for the tap and double-tap detector.
package tscd_pkg;

   localparam int TimeWidth  = 32;
   localparam int AccelWidth = 16;
   localparam int CsrWidth   = 16;
   localparam int CsrIdxWidth = 2;
   localparam int SquareWidth = 2 * AccelWidth - 1;
   localparam int MagWidth    = 32;

   localparam logic [CsrIdxWidth-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_WINDOW    = 2'd2;

   localparam logic [CsrWidth-1:0] THRESHOLD_RESET = 16'd40000;
   localparam logic [CsrWidth-1:0] DEBOUNCE_RESET  = 16'd50;
   localparam logic [CsrWidth-1:0] WINDOW_RESET    = 16'd300;

   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_SINGLE = 2'd1;
   localparam logic [1:0] EVT_DOUBLE = 2'd2;

   typedef struct packed {
      logic [MagWidth-1:0] thr_sq;
      logic [CsrWidth-1:0] debounce;
      logic [CsrWidth-1:0] window;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [TimeWidth-1:0] time_ms;
   } tap_type;

endpackage

FILE: src/tscd_csr.sv
// Configuration registers and the squared threshold derived from them.
module tscd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [tscd_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [tscd_pkg::CsrWidth-1:0]    csr_wdata,
   output tscd_pkg::cfg_type               cfg
);
   import tscd_pkg::*;

   logic [CsrWidth-1:0] thr_ff, thr_in;
   logic [CsrWidth-1:0] deb_ff, deb_in;
   logic [CsrWidth-1:0] win_ff, win_in;
   logic [MagWidth-1:0] thr_sq_ff, thr_sq_in;

   always_comb begin
      thr_in = thr_ff;
      deb_in = deb_ff;
      win_in = win_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in = csr_wdata;
            CSR_DEBOUNCE:  deb_in = csr_wdata;
            CSR_WINDOW:    win_in = csr_wdata;
            default: ;
         endcase
      end
      thr_sq_in = MagWidth'(thr_ff) * MagWidth'(thr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         deb_ff    <= DEBOUNCE_RESET;
         win_ff    <= WINDOW_RESET;
         thr_sq_ff <= MagWidth'(THRESHOLD_RESET) * MagWidth'(THRESHOLD_RESET);
      end else begin
         thr_ff    <= thr_in;
         deb_ff    <= deb_in;
         win_ff    <= win_in;
         thr_sq_ff <= thr_sq_in;
      end
   end

   assign cfg.thr_sq   = thr_sq_ff;
   assign cfg.debounce = deb_ff;
   assign cfg.window   = win_ff;

endmodule

FILE: src/tscd_mag.sv
// Magnitude pipeline: input register, squares, then sum and threshold compare.
module tscd_mag (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tscd_pkg::TimeWidth-1:0]        req_time_ms,
   input  logic signed [tscd_pkg::AccelWidth-1:0] req_accel_x,
   input  logic signed [tscd_pkg::AccelWidth-1:0] req_accel_y,
   input  logic signed [tscd_pkg::AccelWidth-1:0] req_accel_z,
   input  logic [tscd_pkg::MagWidth-1:0]         thr_sq,
   input  logic                                 tap_adv,
   output tscd_pkg::tap_type                    tap
);
   import tscd_pkg::*;

   logic                         in_valid_ff, in_valid_in;
   logic [TimeWidth-1:0]         in_time_ff;
   logic signed [AccelWidth-1:0] in_x_ff, in_y_ff, in_z_ff;

   logic                         sq_valid_ff, sq_valid_in;
   logic [TimeWidth-1:0]         sq_time_ff;
   logic [SquareWidth-1:0]       sq_x_ff, sq_y_ff, sq_z_ff;

   logic                         tap_valid_ff, tap_valid_in;
   logic [TimeWidth-1:0]         tap_time_ff;
   logic                         tap_hit_ff;

   logic signed [2*AccelWidth-1:0] prod_x, prod_y, prod_z;
   logic [MagWidth-1:0]            mag_sq;
   logic                           tap_stage_adv, sq_adv, in_adv;

   // Each stage moves when it is empty or the stage after it moves.
   assign tap_stage_adv = !tap_valid_ff || tap_adv;
   assign sq_adv        = !sq_valid_ff  || tap_stage_adv;
   assign in_adv        = !in_valid_ff  || sq_adv;
   assign req_ready     = in_adv;

   assign prod_x = in_x_ff * in_x_ff;
   assign prod_y = in_y_ff * in_y_ff;
   assign prod_z = in_z_ff * in_z_ff;

   // Each square is at most 2^30, so the sum fits in 32 bits.
   assign mag_sq = MagWidth'(sq_x_ff) + MagWidth'(sq_y_ff) + MagWidth'(sq_z_ff);

   assign in_valid_in  = in_adv        ? req_valid   : in_valid_ff;
   assign sq_valid_in  = sq_adv        ? in_valid_ff : sq_valid_ff;
   assign tap_valid_in = tap_stage_adv ? sq_valid_ff : tap_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
         tap_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         sq_valid_ff  <= sq_valid_in;
         tap_valid_ff <= tap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv) begin
         in_time_ff <= req_time_ms;
         in_x_ff    <= req_accel_x;
         in_y_ff    <= req_accel_y;
         in_z_ff    <= req_accel_z;
      end
      if (sq_adv) begin
         sq_time_ff <= in_time_ff;
         sq_x_ff    <= prod_x[SquareWidth-1:0];
         sq_y_ff    <= prod_y[SquareWidth-1:0];
         sq_z_ff    <= prod_z[SquareWidth-1:0];
      end
      if (tap_stage_adv) begin
         tap_time_ff <= sq_time_ff;
         tap_hit_ff  <= mag_sq > thr_sq;
      end
   end

   assign tap.valid   = tap_valid_ff;
   assign tap.hit     = tap_hit_ff;
   assign tap.time_ms = tap_time_ff;

endmodule

FILE: src/tscd_click.sv
// Click state update and the result register.
module tscd_click (
   input  logic                   clock,
   input  logic                   reset,
   input  tscd_pkg::tap_type      tap,
   input  tscd_pkg::cfg_type      cfg,
   output logic                   tap_adv,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_click_event
);
   import tscd_pkg::*;

   logic [TimeWidth-1:0] last_tap_ff, last_tap_in;
   logic [TimeWidth-1:0] first_tap_ff, first_tap_in;
   logic                 pending_ff, pending_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           evt_ff, evt_in;

   logic [TimeWidth-1:0] since_last, since_first;
   logic                 accepted_tap, in_window, pend_mid;
   logic                 step;

   assign tap_adv = !rsp_valid_ff || rsp_ready;
   assign step    = tap_adv && tap.valid;

   assign since_last   = tap.time_ms - last_tap_ff;
   assign since_first  = tap.time_ms - first_tap_ff;
   assign in_window    = since_first <= TimeWidth'(cfg.window);
   assign accepted_tap = tap.hit && (since_last > TimeWidth'(cfg.debounce));

   always_comb begin
      last_tap_in  = last_tap_ff;
      first_tap_in = first_tap_ff;
      pend_mid     = pending_ff;
      evt_in       = EVT_NONE;
      if (accepted_tap) begin
         if (!pending_ff) begin
            pend_mid     = 1'b1;
            first_tap_in = tap.time_ms;
         end else if (in_window) begin
            evt_in   = EVT_DOUBLE;
            pend_mid = 1'b0;
         end
         last_tap_in = tap.time_ms;
      end
      // A freshly armed click has zero elapsed time, so only an older one can expire.
      pending_in = pend_mid;
      if (pend_mid && pending_ff && !in_window) begin
         evt_in     = EVT_SINGLE;
         pending_in = 1'b0;
      end
      rsp_valid_in = tap_adv ? tap.valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tap_ff  <= '0;
         first_tap_ff <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            last_tap_ff  <= last_tap_in;
            first_tap_ff <= first_tap_in;
            pending_ff   <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         evt_ff <= evt_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_click_event = evt_ff;

endmodule

FILE: src/tap_single_double_click_detector_top.sv
// Top level of the accelerometer tap and double-tap detector.
//
//   channel | direction | payload
//   --------+-----------+----------------------------------------------
//   req_    | in        | time_ms, accel_x, accel_y, accel_z (valid/ready)
//   rsp_    | out       | click_event (valid/ready), one per request
//   csr_    | in        | we, index, wdata (write only, no wait)
//
// One transfer is accepted per cycle while the result channel is not stalled.
// Each result passes through the input, square, compare and result registers in that order.
// Synchronous reset clears the click state and all stage valid flags.
// A stalled result holds every stage behind it; stages fill their bubbles.
module tap_single_double_click_detector_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tscd_pkg::TimeWidth-1:0]          req_time_ms,
   input  logic signed [tscd_pkg::AccelWidth-1:0]  req_accel_x,
   input  logic signed [tscd_pkg::AccelWidth-1:0]  req_accel_y,
   input  logic signed [tscd_pkg::AccelWidth-1:0]  req_accel_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_click_event,
   input  logic                                   csr_we,
   input  logic [tscd_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [tscd_pkg::CsrWidth-1:0]           csr_wdata
);
   import tscd_pkg::*;

   cfg_type cfg;
   tap_type tap;
   logic    tap_adv;

   tscd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tscd_mag u_mag (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_time_ms (req_time_ms),
      .req_accel_x (req_accel_x),
      .req_accel_y (req_accel_y),
      .req_accel_z (req_accel_z),
      .thr_sq      (cfg.thr_sq),
      .tap_adv     (tap_adv),
      .tap         (tap)
   );

   tscd_click u_click (
      .clock           (clock),
      .reset           (reset),
      .tap             (tap),
      .cfg             (cfg),
      .tap_adv         (tap_adv),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_click_event (rsp_click_event)
   );

endmodule
